FILE: src/dsd_pkg.sv
// Package for the dielectric scatter direction unit: request and result types,
// derived index values, side-band types for the pipelined units and reset constants.
// No dependencies.
package dsd_pkg;

	typedef struct packed {
		logic signed [15:0] in_dir_x;
		logic signed [15:0] in_dir_y;
		logic signed [15:0] in_dir_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               entering;
		logic [15:0]        random_fraction;
	} request_t;

	typedef struct packed {
		logic signed [15:0] out_dir_x;
		logic signed [15:0] out_dir_y;
		logic signed [15:0] out_dir_z;
		logic               was_reflected;
		logic               total_internal;
	} result_t;

	// Values derived from the refractive index, all Q16.
	typedef struct packed {
		logic [17:0] eta;
		logic [16:0] recip;
		logic [15:0] r0;
	} cfg_vals_t;

	// Side band carried through the square root pipeline.
	typedef struct packed {
		request_t           req;
		logic signed [17:0] cos_i;
		logic [17:0]        eta;
		logic               tir;
	} sq_side_t;

	// Side band carried through the Schlick pipeline.
	typedef struct packed {
		request_t           req;
		logic signed [17:0] cos_i;
		logic [17:0]        eta;
		logic [16:0]        cos_t;
		logic               tir;
	} sch_side_t;

	typedef enum logic [1:0] {
		CFG_IDLE,
		CFG_RECIP,
		CFG_RATIO,
		CFG_R0
	} cfg_state_t;

	localparam logic [13:0] IdxMin   = 14'd4096;
	localparam logic [13:0] IdxReset = 14'd6144;
	localparam logic [17:0] EtaReset   = 18'd98304;
	localparam logic [16:0] RecipReset = 17'd43691;
	localparam logic [15:0] R0Reset    = 16'd2621;

endpackage

FILE: src/dsd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by dsd_cfg.
module dsd_div #(
	parameter int NumW = 30,
	parameter int DenW = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic [NumW-1:0] quo,
	output logic            done
);

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DenW:0]   rem_sh;
	logic [DenW:0]   rem_nx;
	logic            ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[NumW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[NumW-2:0], ge};
			rem_q <= rem_nx[DenW-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

FILE: src/dsd_cfg.sv
// Index register and the sequencer that derives 1/n and Schlick r0 from it.
// Depends on dsd_pkg and dsd_div.
module dsd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [13:0]       wdata,
	output logic              busy,
	output dsd_pkg::cfg_vals_t vals
);

	dsd_pkg::cfg_state_t state_q, state_nx;
	dsd_pkg::cfg_vals_t  vals_q;
	logic [13:0] n_q;
	logic [13:0] n_in;
	logic [15:0] d_q;
	logic        div_start;
	logic [29:0] div_num;
	logic [14:0] div_den;
	logic [29:0] div_quo;
	logic        div_done;
	logic [32:0] r0_full;

	assign n_in = (wdata < dsd_pkg::IdxMin) ? dsd_pkg::IdxMin : wdata;

	dsd_div #(.NumW(30), .DenW(15)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	// A write always starts the derivation over, even in the middle of one.
	always_comb begin
		state_nx = state_q;
		if (we) begin
			state_nx = dsd_pkg::CFG_RECIP;
		end else begin
			unique case (state_q)
				dsd_pkg::CFG_IDLE:  state_nx = dsd_pkg::CFG_IDLE;
				dsd_pkg::CFG_RECIP: if (div_done) state_nx = dsd_pkg::CFG_RATIO;
				dsd_pkg::CFG_RATIO: if (div_done) state_nx = dsd_pkg::CFG_R0;
				dsd_pkg::CFG_R0:    state_nx = dsd_pkg::CFG_IDLE;
				default:            state_nx = dsd_pkg::CFG_IDLE;
			endcase
		end
	end

	always_comb begin
		div_start = we;
		div_num   = 30'(1 << 28) + 30'(n_in >> 1);
		div_den   = 15'(n_in);
		unique case (state_q)
			dsd_pkg::CFG_IDLE: div_start = we;
			dsd_pkg::CFG_RECIP: if (!we) begin
				div_start = div_done;
				div_num   = {n_q - dsd_pkg::IdxMin, 16'h0000}
					+ 30'((15'(n_q) + 15'(dsd_pkg::IdxMin)) >> 1);
				div_den   = 15'(n_q) + 15'(dsd_pkg::IdxMin);
			end
			dsd_pkg::CFG_RATIO: div_start = we;
			dsd_pkg::CFG_R0:    div_start = we;
			default:            div_start = we;
		endcase
	end

	assign r0_full = {1'b0, 32'(d_q) * 32'(d_q)} + 33'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dsd_pkg::CFG_IDLE;
			n_q          <= dsd_pkg::IdxReset;
			vals_q.eta   <= dsd_pkg::EtaReset;
			vals_q.recip <= dsd_pkg::RecipReset;
			vals_q.r0    <= dsd_pkg::R0Reset;
			d_q          <= '0;
		end else begin
			state_q <= state_nx;
			if (we) begin
				n_q        <= n_in;
				vals_q.eta <= {n_in, 4'b0000};
			end
			if (state_q == dsd_pkg::CFG_RECIP && div_done && !we)
				vals_q.recip <= div_quo[16:0];
			if (state_q == dsd_pkg::CFG_RATIO && div_done && !we) d_q <= div_quo[15:0];
			if (state_q == dsd_pkg::CFG_R0 && !we) vals_q.r0 <= r0_full[31:16];
		end
	end

	assign busy = state_q != dsd_pkg::CFG_IDLE;
	assign vals = vals_q;

endmodule

FILE: src/dsd_sqrt.sv
// Pipelined integer square root, two result bits per stage, with a side band.
// Depends on nothing.
module dsd_sqrt #(
	parameter int SideW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  logic [33:0]      val_i,
	input  logic [SideW-1:0] side_i,
	output logic             vld_o,
	output logic [16:0]      root_o,
	output logic [SideW-1:0] side_o
);

	localparam int Iter  = 17;
	localparam int PerSt = 2;
	localparam int NSt   = (Iter + PerSt - 1) / PerSt;

	logic [NSt:0]      vld_s;
	logic [33:0]       v_s    [NSt+1];
	logic [19:0]       rem_s  [NSt+1];
	logic [16:0]       root_s [NSt+1];
	logic [SideW-1:0]  side_s [NSt+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else vld_s[0] <= vld_i;
	end

	always_ff @(posedge clk) begin
		v_s[0]    <= val_i;
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		side_s[0] <= side_i;
	end

	for (genvar k = 1; k <= NSt; k++) begin : g_st
		logic [19:0] rem_c;
		logic [19:0] trial_c;
		logic [16:0] root_c;
		logic [33:0] v_c;

		always_comb begin
			rem_c   = rem_s[k-1];
			root_c  = root_s[k-1];
			v_c     = v_s[k-1];
			trial_c = '0;
			for (int j = 0; j < PerSt; j++) begin
				if ((k - 1) * PerSt + j < Iter) begin
					rem_c   = {rem_c[17:0], v_c[33:32]};
					v_c     = {v_c[31:0], 2'b00};
					trial_c = {1'b0, root_c, 2'b01};
					if (rem_c >= trial_c) begin
						rem_c  = rem_c - trial_c;
						root_c = {root_c[15:0], 1'b1};
					end else begin
						root_c = {root_c[15:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			v_s[k]    <= v_c;
			rem_s[k]  <= rem_c;
			root_s[k] <= root_c;
			side_s[k] <= side_s[k-1];
		end
	end

	assign vld_o  = vld_s[NSt];
	assign root_o = root_s[NSt];
	assign side_o = side_s[NSt];

endmodule

FILE: src/dsd_schlick.sv
// Pipelined Schlick reflectance r0 + (1 - r0) * (1 - c)^5, Q16, with a side band.
// Depends on nothing.
module dsd_schlick #(
	parameter int SideW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_i,
	input  logic signed [17:0] cos_i,
	input  logic [15:0]        r0,
	input  logic [SideW-1:0]   side_i,
	output logic               vld_o,
	output logic [22:0]        refl_o,
	output logic [SideW-1:0]   side_o
);

	localparam int NPow = 4;

	logic [NPow+1:0]  vld_s;
	logic [17:0]      x_s    [NPow+1];
	logic [21:0]      p_s    [NPow+1];
	logic [SideW-1:0] side_s [NPow+2];
	logic [22:0]      refl_s;
	logic [17:0]      x_in;
	logic [39:0]      fin_prod;

	// One minus the cosine, which lies in [0, 2].
	assign x_in = 18'(19'sd65536 - 19'(cos_i));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else vld_s[0] <= vld_i;
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= x_in;
		p_s[0]    <= 22'(x_in);
		side_s[0] <= side_i;
	end

	for (genvar k = 1; k <= NPow; k++) begin : g_pow
		logic [40:0] prod_c;

		assign prod_c = 41'(40'(p_s[k-1]) * 40'(x_s[k-1])) + 41'd32768;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			x_s[k]    <= x_s[k-1];
			p_s[k]    <= prod_c[37:16];
			side_s[k] <= side_s[k-1];
		end
	end

	assign fin_prod = 40'(39'(17'd65536 - 17'(r0)) * 39'(p_s[NPow])) + 40'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[NPow+1] <= 1'b0;
		else vld_s[NPow+1] <= vld_s[NPow];
	end

	always_ff @(posedge clk) begin
		refl_s         <= 23'(fin_prod[39:16]) + 23'(r0);
		side_s[NPow+1] <= side_s[NPow];
	end

	assign vld_o  = vld_s[NPow+1];
	assign refl_o = refl_s;
	assign side_o = side_s[NPow+1];

endmodule

FILE: src/dielectric_scatter_direction_unit.sv
// Top level of the dielectric scatter direction unit: the dot product, sin^2 and
// output stages, with the square root, Schlick and index units below it.
// Depends on dsd_pkg, dsd_cfg, dsd_div, dsd_sqrt and dsd_schlick.
//
// Usage: a request (incident direction, normal, entering flag, random fraction) is
// taken at a rising edge with start high and busy low. Every request gives exactly
// one result, shown on result for one cycle with done high. The block is a
// pipeline of 25 register stages and takes a new request in every cycle while
// busy is low, so the sustained rate is one request per cycle; results leave in
// request order.
// The receiver cannot stall; results are never held back and the pipeline never
// waits.
// The refractive index is written through cfg_we and cfg_data. A write starts a
// sequencer that derives 1/n and Schlick r0 with one shared bit-serial divider; it
// holds busy high through both divisions and the r0 step, and no request is taken
// during that time. Write only while no request is in flight.
// Reset clears all valid bits and loads n = 1.5 with its derived values, so the
// block accepts requests from the first cycle after reset.
module dielectric_scatter_direction_unit #(
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsd_pkg::request_t request,
	output logic              done,
	output dsd_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [13:0]       cfg_data
);

	localparam int Sh  = 2 * DIR_FRAC_BITS - 16;
	localparam int Dw  = (Sh + 2 > 35) ? Sh + 2 : 35;
	localparam int Lim = (DIR_FRAC_BITS >= 15) ? 32767 : (1 << DIR_FRAC_BITS);
	localparam logic signed [Dw-1:0] Half   = Dw'(1) <<< (Sh - 1);
	localparam logic signed [Dw-1:0] QOneW  = Dw'(65536);
	localparam logic signed [23:0]   LimW   = 24'(Lim);
	localparam logic signed [15:0]   LimS   = 16'(Lim);
	localparam int SqSideW  = $bits(dsd_pkg::sq_side_t);
	localparam int SchSideW = $bits(dsd_pkg::sch_side_t);

	dsd_pkg::cfg_vals_t vals;
	logic accept;

	// The index unit owns busy; requests are held off only while it derives.
	dsd_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.wdata (cfg_data),
		.busy  (busy),
		.vals  (vals)
	);

	assign accept = start && !busy;

	// Stage 1: the three products of the dot product.
	logic v_s1;
	dsd_pkg::request_t req_s1;
	logic signed [31:0] pd_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		req_s1   <= request;
		pd_s1[0] <= request.in_dir_x * request.norm_x;
		pd_s1[1] <= request.in_dir_y * request.norm_y;
		pd_s1[2] <= request.in_dir_z * request.norm_z;
	end

	// Stage 2: cos_i = -dot rescaled to Q16, the dot rounded half up, clamped to [-1, 1].
	logic v_s2;
	dsd_pkg::request_t req_s2;
	logic signed [17:0] c_s2;
	logic signed [Dw-1:0] dot_w, rnd_w, negc_w;
	logic signed [17:0] c_nx;

	always_comb begin
		dot_w  = Dw'(pd_s1[0]) + Dw'(pd_s1[1]) + Dw'(pd_s1[2]);
		rnd_w  = (dot_w + Half) >>> Sh;
		negc_w = -rnd_w;
		if (negc_w > QOneW) c_nx = 18'sd65536;
		else if (negc_w < -QOneW) c_nx = -18'sd65536;
		else c_nx = negc_w[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		req_s2 <= req_s1;
		c_s2   <= c_nx;
	end

	// Stage 3: cos_i squared and the ratio squared. Entering uses 1/n, leaving n.
	logic v_s3;
	dsd_pkg::request_t req_s3;
	logic signed [17:0] c_s3;
	logic [17:0] eta_s3;
	logic [32:0] cc_s3;
	logic [35:0] ee_s3;
	logic [17:0] eta_sel;
	logic signed [35:0] cc_w;

	assign eta_sel = req_s2.entering ? {1'b0, vals.recip} : vals.eta;
	assign cc_w    = c_s2 * c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		req_s3 <= req_s2;
		c_s3   <= c_s2;
		eta_s3 <= eta_sel;
		cc_s3  <= cc_w[32:0];
		ee_s3  <= eta_sel * eta_sel;
	end

	// Stage 4: round both squares to Q16; om = 1 - cos_i^2.
	logic v_s4;
	dsd_pkg::request_t req_s4;
	logic signed [17:0] c_s4;
	logic [17:0] eta_s4;
	logic [16:0] om_s4;
	logic [20:0] ee_s4;
	logic [33:0] cc_r;
	logic [36:0] ee_r;

	assign cc_r = 34'(cc_s3) + 34'd32768;
	assign ee_r = 37'(ee_s3) + 37'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		req_s4 <= req_s3;
		c_s4   <= c_s3;
		eta_s4 <= eta_s3;
		om_s4  <= 17'd65536 - cc_r[32:16];
		ee_s4  <= ee_r[36:16];
	end

	// Stage 5: sin^2 of the transmitted angle.
	logic v_s5;
	dsd_pkg::request_t req_s5;
	logic signed [17:0] c_s5;
	logic [17:0] eta_s5;
	logic [22:0] s2_s5;
	logic [38:0] s2_r;

	assign s2_r = 39'(38'(ee_s4) * 38'(om_s4)) + 39'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		req_s5 <= req_s4;
		c_s5   <= c_s4;
		eta_s5 <= eta_s4;
		s2_s5  <= s2_r[38:16];
	end

	// Transmitted cosine: floor sqrt of max(0, 1 - sin^2) in Q32. Leaving with
	// sin^2 above one is total internal reflection.
	dsd_pkg::sq_side_t sq_in, sq_out;
	logic        over_one;
	logic [16:0] t_w;
	logic        sq_vld;
	logic [16:0] sq_root;
	logic [SqSideW-1:0] sq_side_bits;

	assign over_one    = s2_s5 > 23'd65536;
	assign t_w         = over_one ? 17'd0 : 17'(23'd65536 - s2_s5);
	assign sq_in.req   = req_s5;
	assign sq_in.cos_i = c_s5;
	assign sq_in.eta   = eta_s5;
	assign sq_in.tir   = !req_s5.entering && over_one;

	dsd_sqrt #(.SideW(SqSideW)) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (v_s5),
		.val_i ({1'b0, t_w, 16'h0000}),
		.side_i(sq_in),
		.vld_o (sq_vld),
		.root_o(sq_root),
		.side_o(sq_side_bits)
	);

	assign sq_out = dsd_pkg::sq_side_t'(sq_side_bits);

	// Schlick reflectance at cos_i when entering, at the transmitted cosine when leaving.
	dsd_pkg::sch_side_t sch_in, sch_out;
	logic signed [17:0] sch_cos;
	logic        sch_vld;
	logic [22:0] sch_val;
	logic [SchSideW-1:0] sch_side_bits;

	assign sch_in.req   = sq_out.req;
	assign sch_in.cos_i = sq_out.cos_i;
	assign sch_in.eta   = sq_out.eta;
	assign sch_in.cos_t = sq_root;
	assign sch_in.tir   = sq_out.tir;
	assign sch_cos      = sq_out.req.entering ? sq_out.cos_i : $signed({1'b0, sq_root});

	dsd_schlick #(.SideW(SchSideW)) u_schlick (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (sq_vld),
		.cos_i (sch_cos),
		.r0    (vals.r0),
		.side_i(sch_in),
		.vld_o (sch_vld),
		.refl_o(sch_val),
		.side_o(sch_side_bits)
	);

	assign sch_out = dsd_pkg::sch_side_t'(sch_side_bits);

	// Stage 6: decide reflection, start eta * cos_i for the refraction term.
	logic v_s6;
	dsd_pkg::request_t req_s6;
	logic signed [17:0] c_s6;
	logic [17:0] eta_s6;
	logic [16:0] ct_s6;
	logic refl_s6, tir_s6;
	logic signed [36:0] ek_s6;
	logic fres_hit;

	assign fres_hit = sch_val > {7'b0, sch_out.req.random_fraction};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= sch_vld;
	end

	always_ff @(posedge clk) begin
		req_s6  <= sch_out.req;
		c_s6    <= sch_out.cos_i;
		eta_s6  <= sch_out.eta;
		ct_s6   <= sch_out.cos_t;
		tir_s6  <= sch_out.tir;
		refl_s6 <= sch_out.tir || fres_hit;
		ek_s6   <= $signed({1'b0, sch_out.eta}) * sch_out.cos_i;
	end

	// Stage 7: k = eta*cos_i - cos_t; first product per component, 2*cos_i*n on
	// reflection and eta*d on refraction.
	logic v_s7;
	logic refl_s7, tir_s7;
	logic signed [21:0] k_s7;
	logic signed [35:0] pr_s7 [3];
	logic signed [15:0] d_s7 [3];
	logic signed [15:0] n_s7 [3];
	logic signed [15:0] d6 [3];
	logic signed [15:0] n6 [3];
	logic signed [36:0] ek_r;
	logic signed [19:0] mul_a;

	always_comb begin
		d6[0] = req_s6.in_dir_x;
		d6[1] = req_s6.in_dir_y;
		d6[2] = req_s6.in_dir_z;
		n6[0] = req_s6.norm_x;
		n6[1] = req_s6.norm_y;
		n6[2] = req_s6.norm_z;
		ek_r  = (ek_s6 + 37'sd32768) >>> 16;
		mul_a = refl_s6 ? 20'(c_s6) <<< 1 : $signed({2'b00, eta_s6});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		refl_s7 <= refl_s6;
		tir_s7  <= tir_s6;
		k_s7    <= 22'(ek_r) - $signed({5'b0, ct_s6});
		for (int i = 0; i < 3; i++) begin
			pr_s7[i] <= mul_a * (refl_s6 ? n6[i] : d6[i]);
			d_s7[i]  <= d6[i];
			n_s7[i]  <= n6[i];
		end
	end

	// Stage 8: k * n per component.
	logic v_s8;
	logic refl_s8, tir_s8;
	logic signed [35:0] pr_s8 [3];
	logic signed [37:0] q_s8 [3];
	logic signed [15:0] d_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		refl_s8 <= refl_s7;
		tir_s8  <= tir_s7;
		for (int i = 0; i < 3; i++) begin
			pr_s8[i] <= pr_s7[i];
			q_s8[i]  <= k_s7 * n_s7[i];
			d_s8[i]  <= d_s7[i];
		end
	end

	// Output stage: round, add, saturate to the unit range of the direction format.
	function automatic logic signed [15:0] sat_dir(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > LimW) r = LimS;
		else if (v < -LimW) r = -LimS;
		else r = v[15:0];
		return r;
	endfunction

	logic signed [15:0] o_w [3];
	logic signed [36:0] rr_w [3];
	logic signed [38:0] rf_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rr_w[i] = (37'(pr_s8[i]) + 37'sd32768) >>> 16;
			rf_w[i] = (39'(pr_s8[i]) + 39'(q_s8[i]) + 39'sd32768) >>> 16;
			o_w[i]  = refl_s8 ? sat_dir(24'(d_s8[i]) + 24'(rr_w[i])) : sat_dir(24'(rf_w[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s8;
	end

	always_ff @(posedge clk) begin
		result.out_dir_x      <= o_w[0];
		result.out_dir_y      <= o_w[1];
		result.out_dir_z      <= o_w[2];
		result.was_reflected  <= refl_s8;
		result.total_internal <= tir_s8;
	end

	// No request may enter the pipeline while the index unit is deriving.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !v_s1) else $error("request entered while busy");

	// An index write always starts a derivation.
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && !busy) |=> busy) else $error("index write did not raise busy");

	// Total internal reflection is always reported as a reflection.
	a_tir_refl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.total_internal || result.was_reflected))
		else $error("total internal reflection without reflection");

	// Every component stays inside the saturation range.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_dir_x <= LimS && result.out_dir_x >= -LimS
			&& result.out_dir_y <= LimS && result.out_dir_y >= -LimS
			&& result.out_dir_z <= LimS && result.out_dir_z >= -LimS))
		else $error("direction component out of range");

endmodule

FILE: tb/sv/dielectric_scatter_direction_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the dielectric scatter direction unit: directed and random ray hits
// under several refractive indices, checked against a built-in fixed-point predictor.
// Depends on dsd_pkg and dielectric_scatter_direction_unit.
module dielectric_scatter_direction_unit_tb;

	localparam int FracBits = 14;
	localparam int PipeLatency = 25;
	localparam longint QOne = 65536;
	localparam int CycleLimit = 300000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	dsd_pkg::request_t  request;
	logic      done;
	dsd_pkg::result_t   result;
	logic      cfg_we;
	logic [13:0] cfg_data;

	dielectric_scatter_direction_unit #(.DIR_FRAC_BITS(FracBits)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the index register and the values derived from it (all Q16).
	longint idx_eta;
	longint idx_recip;
	longint idx_r0;

	// Scattered directions expected back, oldest first.
	dsd_pkg::result_t pending_dirs[$];
	int error_count = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes far below this bound.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("dielectric_scatter_direction_unit_tb: errors");
			$finish;
		end
	end

	// Rounding right shift: add half, then an arithmetic (flooring) shift.
	function automatic longint round_shift(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint q16_mul(longint a, longint b);
		return round_shift(a * b, 16);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Recompute eta, 1/n and Schlick r0 for a newly written index. Indices below
	// one are taken as exactly one.
	function automatic void load_index(logic [13:0] value);
		longint n;
		longint ratio;
		n = value;
		if (n < 4096)
			n = 4096;
		idx_eta = n << 4;
		idx_recip = ((longint'(1) << 28) + n / 2) / n;
		ratio = (((n - 4096) << 16) + (n + 4096) / 2) / (n + 4096);
		idx_r0 = q16_mul(ratio, ratio);
	endfunction

	function automatic longint schlick_refl(longint cosv);
		longint x;
		longint p;
		x = QOne - cosv;
		p = x;
		for (int k = 0; k < 4; k++)
			p = q16_mul(p, x);
		return idx_r0 + q16_mul(QOne - idx_r0, p);
	endfunction

	function automatic logic [15:0] clamp_dir(longint v);
		longint lim;
		lim = longint'(1) << FracBits;
		if (lim > 32767)
			lim = 32767;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v[15:0];
	endfunction

	function automatic dsd_pkg::result_t predict_scatter(dsd_pkg::request_t r);
		longint d[3];
		longint nv[3];
		longint o[3];
		longint dot;
		longint cos_i;
		longint eta;
		longint s2;
		longint cos_t;
		longint t;
		longint k;
		bit refl;
		bit tir;
		dsd_pkg::result_t res;
		d[0] = r.in_dir_x;
		d[1] = r.in_dir_y;
		d[2] = r.in_dir_z;
		nv[0] = r.norm_x;
		nv[1] = r.norm_y;
		nv[2] = r.norm_z;
		dot = 0;
		for (int i = 0; i < 3; i++)
			dot += d[i] * nv[i];
		// cos_i is clamped to [-1, 1] so that vectors that are not unit stay sane.
		cos_i = -round_shift(dot, 2 * FracBits - 16);
		if (cos_i > QOne)
			cos_i = QOne;
		if (cos_i < -QOne)
			cos_i = -QOne;
		eta = r.entering ? idx_recip : idx_eta;
		s2 = q16_mul(q16_mul(eta, eta), QOne - q16_mul(cos_i, cos_i));
		tir = 1'b0;
		if (r.entering) begin
			refl = schlick_refl(cos_i) > longint'(r.random_fraction);
		end else if (s2 > QOne) begin
			refl = 1'b1;
			tir = 1'b1;
		end else begin
			cos_t = int_sqrt(longint'(QOne - s2) << 16);
			refl = schlick_refl(cos_t) > longint'(r.random_fraction);
		end
		if (refl) begin
			for (int i = 0; i < 3; i++)
				o[i] = d[i] + round_shift(2 * cos_i * nv[i], 16);
		end else begin
			// A negative argument under the root is raised to zero.
			t = QOne - s2;
			if (t < 0)
				t = 0;
			cos_t = int_sqrt(t << 16);
			k = q16_mul(eta, cos_i) - cos_t;
			for (int i = 0; i < 3; i++)
				o[i] = round_shift(eta * d[i] + k * nv[i], 16);
		end
		res.out_dir_x = clamp_dir(o[0]);
		res.out_dir_y = clamp_dir(o[1]);
		res.out_dir_z = clamp_dir(o[2]);
		res.was_reflected = refl;
		res.total_internal = tir;
		return res;
	endfunction

	// Result checker: the strobe is sampled at the edge that ends its cycle.
	always @(posedge clk) begin
		dsd_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_dirs.size() == 0) begin
				$display("%0t: result with no request outstanding: %p", $time, result);
				error_count++;
			end else begin
				want = pending_dirs.pop_front();
				if (result.out_dir_x !== want.out_dir_x)
					$display("%0t: out_dir_x expected %0d actual %0d", $time,
						want.out_dir_x, result.out_dir_x);
				if (result.out_dir_y !== want.out_dir_y)
					$display("%0t: out_dir_y expected %0d actual %0d", $time,
						want.out_dir_y, result.out_dir_y);
				if (result.out_dir_z !== want.out_dir_z)
					$display("%0t: out_dir_z expected %0d actual %0d", $time,
						want.out_dir_z, result.out_dir_z);
				if (result.was_reflected !== want.was_reflected)
					$display("%0t: was_reflected expected %0b actual %0b", $time,
						want.was_reflected, result.was_reflected);
				if (result.total_internal !== want.total_internal)
					$display("%0t: total_internal expected %0b actual %0b", $time,
						want.total_internal, result.total_internal);
				if (result !== want)
					error_count++;
			end
		end
	end

	// Send one request after a random gap. Start is left high after acceptance so
	// that back-to-back requests need no second assignment in the same step.
	task automatic send_hit(dsd_pkg::request_t r);
		int gap;
		gap = $urandom_range(0, 9);
		if ((cycle_count / 200) % 3 == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_dirs.push_back(predict_scatter(r));
	endtask

	// Lower start and wait until every result is back plus the pipeline depth.
	task automatic drain_pipe();
		start <= 1'b0;
		while (pending_dirs.size() != 0)
			@(posedge clk);
		repeat (PipeLatency + 5) @(posedge clk);
	endtask

	task automatic write_index(logic [13:0] value);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_index(value);
		// The derivation sequencer raises busy; wait for it to fall again.
		repeat (2) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] to_q14(real v);
		return 16'($rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5)));
	endfunction

	// Random unit vector in Q1.14.
	task automatic unit_vec(output logic signed [15:0] x, output logic signed [15:0] y,
			output logic signed [15:0] z);
		real a;
		real b;
		real c;
		real len;
		do begin
			a = real'($urandom_range(0, 2000)) - 1000.0;
			b = real'($urandom_range(0, 2000)) - 1000.0;
			c = real'($urandom_range(0, 2000)) - 1000.0;
			len = $sqrt(a * a + b * b + c * c);
		end while (len < 1.0);
		x = to_q14(a / len);
		y = to_q14(b / len);
		z = to_q14(c / len);
	endtask

	function automatic dsd_pkg::request_t make_hit(int dx, int dy, int dz, int nx, int ny,
			int nz, bit ent, int rnd);
		dsd_pkg::request_t r;
		r.in_dir_x = 16'(dx);
		r.in_dir_y = 16'(dy);
		r.in_dir_z = 16'(dz);
		r.norm_x = 16'(nx);
		r.norm_y = 16'(ny);
		r.norm_z = 16'(nz);
		r.entering = ent;
		r.random_fraction = 16'(rnd);
		return r;
	endfunction

	// Axis hits, grazing hits, total internal reflection, non-unit and zero vectors,
	// random fraction extremes.
	task automatic test_directed();
		send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 1'b1, 0));
		send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 1'b1, 65535));
		send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 1'b0, 0));
		send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 1'b0, 65535));
		send_hit(make_hit(16384, 0, 0, 0, 16384, 0, 1'b1, 1000));
		send_hit(make_hit(16384, 0, 0, 0, 16384, 0, 1'b0, 1000));
		send_hit(make_hit(15000, 0, -6580, 0, 0, 16384, 1'b1, 30000));
		send_hit(make_hit(15000, 0, 6580, 0, 0, -16384, 1'b0, 30000));
		send_hit(make_hit(11585, 0, 11585, 0, 0, -16384, 1'b0, 0));
		send_hit(make_hit(6000, 0, 15245, 0, 0, -16384, 1'b0, 65535));
		send_hit(make_hit(-16384, -16384, -16384, 16384, 16384, 16384, 1'b1, 0));
		send_hit(make_hit(16384, 16384, 16384, 16384, 16384, 16384, 1'b0, 65535));
		send_hit(make_hit(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0, 12345));
		send_hit(make_hit(32767, 32767, 32767, -32768, -32768, -32768, 1'b1, 40000));
		send_hit(make_hit(0, 0, 0, 0, 0, 0, 1'b1, 0));
		send_hit(make_hit(0, 0, 0, 0, 0, 0, 1'b0, 65535));
		send_hit(make_hit(-16384, 0, 0, -16384, 0, 0, 1'b1, 500));
		send_hit(make_hit(0, -11585, -11585, 0, 16384, 0, 1'b1, 2000));
		send_hit(make_hit(0, 11585, 11585, 0, -16384, 0, 1'b0, 2000));
	endtask

	// Mostly physical hits with random content; the rest raw noise.
	task automatic test_random(int count);
		dsd_pkg::request_t r;
		longint dot;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 85) begin
				unit_vec(r.in_dir_x, r.in_dir_y, r.in_dir_z);
				unit_vec(r.norm_x, r.norm_y, r.norm_z);
				dot = r.in_dir_x * r.norm_x + r.in_dir_y * r.norm_y
					+ r.in_dir_z * r.norm_z;
				// Entering when the ray faces the normal, with occasional mismatch.
				r.entering = (dot < 0);
				if ($urandom_range(0, 9) == 0)
					r.entering = ~r.entering;
				r.random_fraction = 16'($urandom);
			end else begin
				r = dsd_pkg::request_t'($bits(dsd_pkg::request_t)'(
					{$urandom, $urandom, $urandom, $urandom}));
			end
			send_hit(r);
		end
	endtask

	// Index extremes, including values below one and zero.
	task automatic test_index_settings();
		write_index(14'd16383);
		test_directed();
		test_random(60);
		write_index(14'd4096);
		test_directed();
		test_random(40);
		write_index(14'd0);
		test_random(20);
		write_index(14'd100);
		test_random(20);
		write_index(14'($urandom_range(4096, 16383)));
		test_random(60);
		write_index(dsd_pkg::IdxReset);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		load_index(dsd_pkg::IdxReset);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		test_index_settings();
		test_random(50);

		drain_pipe();
		if (error_count == 0) begin
			$display("dielectric_scatter_direction_unit_tb: clean");
		end else begin
			$display("dielectric_scatter_direction_unit_tb: errors");
		end
		$finish;
	end

endmodule
